// File: rtl/ddmm_pkg.sv
`default_nettype none
package ddmm_pkg;

	localparam int LEN_W   = 6;
	localparam int MASK_W  = 13;
	localparam int COUNT_W = 8;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

	typedef enum logic [1:0] {
		MODE_MASK_WR = 2'd0,
		MODE_HDR_WR  = 2'd1,
		MODE_CLEAR   = 2'd2,
		MODE_KEY     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_PARTIAL = 2'd1,
		ST_FULL    = 2'd2
	} match_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_WALK,
		CS_DRAIN
	} ctrl_state_t;

	typedef struct packed {
		logic mask_wr;
		logic hdr_wr;
		logic clear;
		logic start;
		logic issue;
		logic load_result;
	} ctrl_cmd_t;

	typedef struct packed {
		logic issue_last;
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// File: rtl/ddmm_ctrl.sv
`default_nettype none
module ddmm_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire logic [1:0]             mode,
	input  wire ddmm_pkg::dp_status_t   st,
	output ddmm_pkg::ctrl_cmd_t         cmd
);
	import ddmm_pkg::*;

	ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx   = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			CS_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					case (mode)
						MODE_MASK_WR: cmd.mask_wr = 1'b1;
						MODE_HDR_WR:  cmd.hdr_wr  = 1'b1;
						MODE_CLEAR:   cmd.clear   = 1'b1;
						MODE_KEY: begin
							cmd.start = 1'b1;
							state_nx  = CS_WALK;
						end
						default: ;
					endcase
				end
			end
			CS_WALK: begin
				cmd.issue = 1'b1;
				if (st.issue_last) begin
					state_nx = CS_DRAIN;
				end
			end
			CS_DRAIN: begin
				// wait for the last entry to leave the pipe and the output slot to free up
				if (!st.pipe_busy && st.out_free) begin
					cmd.load_result = 1'b1;
					state_nx        = CS_IDLE;
				end
			end
			default: state_nx = CS_IDLE;
		endcase
	end

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		st.pipe_busy |-> item_stall)
		else $error("transaction accepted while entry walk in flight");

endmodule
`default_nettype wire

// File: rtl/ddmm_dpath.sv
`default_nettype none
module ddmm_dpath #(
	parameter int ENTRIES   = 16,
	parameter int POSITIONS = 32,
	parameter int KEY_IDS   = 13
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ddmm_pkg::ctrl_cmd_t    cmd,
	output ddmm_pkg::dp_status_t        st,
	input  wire logic [3:0]             entry,
	input  wire logic [4:0]             position,
	input  wire logic [12:0]            mask,
	input  wire logic [5:0]             length,
	input  wire logic                   variable,
	input  wire logic [3:0]             key,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic [1:0]                  status,
	output logic                        dial_complete
);
	import ddmm_pkg::*;

	localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PW = $clog2(POSITIONS);
	localparam int AW = $clog2(ENTRIES * POSITIONS);

	// table storage
	logic [MASK_W-1:0] mask_mem [ENTRIES*POSITIONS];
	logic [LEN_W:0]    hdr_mem  [ENTRIES];
	logic [ENTRIES-1:0] hdr_valid_q;
	logic [ENTRIES-1:0] running_q;

	// dialing state
	logic [COUNT_W-1:0] key_count_q;
	logic [MASK_W-1:0]  km_q;
	logic [EW-1:0]      walk_e_q;
	logic               any_full_q, any_partial_q;

	// pipeline
	logic               valid_s1, hv_s1;
	logic [EW-1:0]      e_s1;
	logic [LEN_W:0]     hdr_s1;
	logic               valid_s2, skip_s2, rep_s2, lt_s2, eq_s2, a_ok_s2, b_ok_s2;
	logic [EW-1:0]      e_s2;
	logic [MASK_W-1:0]  rd_a_s2, rd_b_s2;

	// output register
	logic               result_valid_q, dial_complete_q;
	logic [1:0]         status_q;

	// write decode
	logic [7:0]    ent_ext, pos_ext;
	logic          ent_ok, pos_ok;
	logic [EW-1:0] ent_idx;
	logic [AW-1:0] wr_addr;

	always_comb begin
		ent_ext = {4'b0, entry};
		pos_ext = {3'b0, position};
		ent_ok  = ent_ext < 8'(ENTRIES);
		pos_ok  = pos_ext < 8'(POSITIONS);
		ent_idx = ent_ext[EW-1:0];
		wr_addr = AW'(ent_idx) * AW'(POSITIONS) + AW'(pos_ext[PW-1:0]);
	end

	// key press setup
	logic [COUNT_W-1:0] n_nx;
	logic [MASK_W-1:0]  km_nx;

	always_comb begin
		n_nx  = (key_count_q == COUNT_MAX) ? COUNT_MAX : key_count_q + COUNT_W'(1);
		km_nx = '0;
		if (int'(key) < KEY_IDS && int'(key) < MASK_W) begin
			km_nx = MASK_W'(1) << key;
		end
	end

	// stage 1: decode header, form mask addresses
	logic [LEN_W-1:0]   len_e, lp;
	logic               var_e, rep_ph, skip_e, lt_e, eq_e, a_ok, b_ok;
	logic [COUNT_W-1:0] idx, pa, pb;
	logic [AW-1:0]      addr_a, addr_b;

	always_comb begin
		len_e  = hv_s1 ? hdr_s1[LEN_W-1:0] : '0;
		var_e  = hv_s1 & hdr_s1[LEN_W];
		lp     = len_e - LEN_W'(1);
		idx    = key_count_q - COUNT_W'(1);
		rep_ph = var_e && (key_count_q > {2'b0, lp});
		skip_e = (len_e == '0) || (var_e && len_e < LEN_W'(2));
		lt_e   = var_e || (key_count_q < {2'b0, len_e});
		eq_e   = !var_e && (key_count_q == {2'b0, len_e});
		pa     = rep_ph ? {2'b0, lp - LEN_W'(1)} : idx;
		pb     = {2'b0, lp};
		a_ok   = pa < 8'(POSITIONS);
		b_ok   = pb < 8'(POSITIONS);
		addr_a = AW'(e_s1) * AW'(POSITIONS) + AW'(pa[PW-1:0]);
		addr_b = AW'(e_s1) * AW'(POSITIONS) + AW'(pb[PW-1:0]);
	end

	// stage 2: evaluate the entry
	logic run, fit_a, fit_b, hit, full_e, part_e, run_nx;

	always_comb begin
		run   = running_q[e_s2];
		fit_a = a_ok_s2 && |(km_q & rd_a_s2);
		fit_b = b_ok_s2 && |(km_q & rd_b_s2);
		hit   = run && fit_a;
		if (rep_s2) begin
			full_e = fit_b && run;
			part_e = !fit_b && hit;
			run_nx = hit;
		end else begin
			full_e = eq_s2 && hit;
			part_e = lt_s2 && hit;
			run_nx = (lt_s2 || eq_s2) && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mask_wr && ent_ok && pos_ok) begin
			mask_mem[wr_addr] <= mask;
		end
		rd_a_s2 <= mask_mem[addr_a];
		rd_b_s2 <= mask_mem[addr_b];
	end

	always_ff @(posedge clk) begin
		if (cmd.hdr_wr && ent_ok) begin
			hdr_mem[ent_idx] <= {variable, length};
		end
		hdr_s1 <= hdr_mem[walk_e_q];
	end

	always_ff @(posedge clk) begin
		e_s1    <= walk_e_q;
		e_s2    <= e_s1;
		skip_s2 <= skip_e;
		rep_s2  <= rep_ph;
		lt_s2   <= lt_e;
		eq_s2   <= eq_e;
		a_ok_s2 <= a_ok;
		b_ok_s2 <= b_ok;
		if (cmd.start) begin
			km_q <= km_nx;
		end
		if (cmd.load_result) begin
			status_q        <= any_full_q ? ST_FULL : (any_partial_q ? ST_PARTIAL : ST_NONE);
			dial_complete_q <= any_full_q || !any_partial_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_valid_q    <= '0;
			running_q      <= '1;
			key_count_q    <= '0;
			walk_e_q       <= '0;
			any_full_q     <= 1'b0;
			any_partial_q  <= 1'b0;
			valid_s1       <= 1'b0;
			hv_s1          <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			hv_s1    <= hdr_valid_q[walk_e_q];
			valid_s2 <= valid_s1;
			if (cmd.hdr_wr && ent_ok) begin
				hdr_valid_q[ent_idx] <= 1'b1;
			end
			if (cmd.clear) begin
				key_count_q <= '0;
				running_q   <= '1;
			end
			if (cmd.start) begin
				key_count_q   <= n_nx;
				walk_e_q      <= '0;
				any_full_q    <= 1'b0;
				any_partial_q <= 1'b0;
			end else if (cmd.issue) begin
				walk_e_q <= walk_e_q + EW'(1);
			end
			// skipped entries keep their running bit
			if (valid_s2 && !skip_s2) begin
				running_q[e_s2] <= run_nx;
				any_full_q      <= any_full_q | full_e;
				any_partial_q   <= any_partial_q | part_e;
			end
			if (cmd.load_result) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st.issue_last = walk_e_q == EW'(ENTRIES - 1);
		st.pipe_busy  = valid_s1 || valid_s2;
		st.out_free   = !result_valid_q || !result_stall;
	end

	assign result_valid  = result_valid_q;
	assign status        = status_q;
	assign dial_complete = dial_complete_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> !cmd.load_result)
		else $error("pending result overwritten");

	a_complete_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (dial_complete == (status != ST_PARTIAL)))
		else $error("dial_complete disagrees with status");

	a_walk_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (walk_e_q == '0) && !any_full_q && !any_partial_q && !valid_s2)
		else $error("walk started with stale state");

endmodule
`default_nettype wire

// File: rtl/dial_digit_map_matcher.sv
`default_nettype none
// Table writes and clear take effect in the cycle after the transaction; they are taken
// one per cycle while no key press is in flight. A key press walks every entry, reading
// one header and two mask words per cycle, through the decode and evaluate stages, and then
// loads its result once the pipe drains and the output slot frees; items stall until then.
// Reset (arst_n low): all entries empty, running bits set, key count zero, no result pending.
// Mask words are not cleared and hold garbage until written.
module dial_digit_map_matcher #(
	parameter int ENTRIES   = 16,
	parameter int POSITIONS = 32,
	parameter int KEY_IDS   = 13
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [3:0]  entry,
	input  wire logic [4:0]  position,
	input  wire logic [12:0] mask,
	input  wire logic [5:0]  length,
	input  wire logic        variable,
	input  wire logic [3:0]  key,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       status,
	output logic             dial_complete
);
	import ddmm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t st;

	ddmm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.st         (st),
		.cmd        (cmd)
	);

	ddmm_dpath #(
		.ENTRIES   (ENTRIES),
		.POSITIONS (POSITIONS),
		.KEY_IDS   (KEY_IDS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.entry         (entry),
		.position      (position),
		.mask          (mask),
		.length        (length),
		.variable      (variable),
		.key           (key),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.status        (status),
		.dial_complete (dial_complete)
	);

endmodule
`default_nettype wire

// File: test/dial_digit_map_matcher_tb.sv
module dial_digit_map_matcher_tb;
	import ddmm_pkg::*;

	localparam int N_ENTRIES = 16;
	localparam int N_POS     = 32;
	localparam int N_KEYS    = 13;

	typedef struct packed {
		match_t status;
		logic   complete;
	} key_verdict_t;

	// Tracks the digit-map table and the dialing state, and predicts each key result.
	class digit_map_tracker;
		bit [12:0]    masks[N_ENTRIES][N_POS];
		bit [5:0]     lens[N_ENTRIES];
		bit           dot_form[N_ENTRIES];
		bit           running[N_ENTRIES];
		int unsigned  presses;
		bit           saturated;
		key_verdict_t verdicts_due[$];
		int           errors;
		int           shown;
		int           checked;
		int           fulls;
		int           partials;

		function new();
			restart_dial();
		endfunction

		function void restart_dial();
			presses = 0;
			foreach (running[e])
				running[e] = 1'b1;
		endfunction

		function bit [12:0] mask_of(int e, int p);
			if (p >= N_POS)
				return '0;
			return masks[e][p];
		endfunction

		function key_verdict_t match_key(bit [3:0] k);
			key_verdict_t verdict;
			int           n;
			int           l;
			int           lp;
			bit [12:0]    km;
			bit           full_hit;
			bit           part_hit;
			bit           hit;
			bit           rep;
			bit           run;
			full_hit = 1'b0;
			part_hit = 1'b0;
			n = (presses < 255) ? presses + 1 : 255;
			presses = n;
			if (n == 255)
				saturated = 1'b1;
			km = '0;
			if (k < N_KEYS)
				km[k] = 1'b1;
			for (int e = 0; e < N_ENTRIES; e++) begin
				l = int'(lens[e]);
				run = running[e];
				if (l == 0)
					continue;
				if (!dot_form[e]) begin
					hit = run && (km & mask_of(e, n - 1)) != 0;
					if (n < l)
						part_hit |= hit;
					else if (n == l)
						full_hit |= hit;
					else
						hit = 1'b0;
					running[e] = hit;
				end else if (l >= 2) begin
					lp = l - 1;
					if (n <= lp) begin
						hit = run && (km & mask_of(e, n - 1)) != 0;
						part_hit |= hit;
						running[e] = hit;
					end else begin
						// past the prefix: the element before the terminator repeats
						rep = run && (km & mask_of(e, lp - 1)) != 0;
						if ((km & mask_of(e, lp)) != 0)
							full_hit |= run;
						else
							part_hit |= rep;
						running[e] = rep;
					end
				end
			end
			verdict.status = full_hit ? ST_FULL : (part_hit ? ST_PARTIAL : ST_NONE);
			verdict.complete = (verdict.status != ST_PARTIAL);
			return verdict;
		endfunction

		function void note_transaction(mode_t m, bit [3:0] e, bit [4:0] p, bit [12:0] msk,
				bit [5:0] len, bit dot, bit [3:0] k);
			case (m)
				MODE_MASK_WR: masks[e][p] = msk;
				MODE_HDR_WR: begin
					lens[e] = len;
					dot_form[e] = dot;
				end
				MODE_CLEAR: restart_dial();
				MODE_KEY: verdicts_due.push_back(match_key(k));
				default: ;
			endcase
		endfunction

		function void complain(string what);
			errors++;
			if (shown < 100)
				$display("%0t: %s", $time, what);
			else if (shown == 100)
				$display("%0t: further mismatch reports suppressed", $time);
			shown++;
		endfunction

		function void check_result(logic [1:0] st, logic dc);
			key_verdict_t want;
			if (verdicts_due.size() == 0) begin
				complain($sformatf("result with none expected: status %0d complete %0b",
					st, dc));
				return;
			end
			want = verdicts_due.pop_front();
			checked++;
			if (want.status == ST_FULL)
				fulls++;
			else if (want.status == ST_PARTIAL)
				partials++;
			if (st !== want.status)
				complain($sformatf("status expected %0d actual %0d", want.status, st));
			if (dc !== want.complete)
				complain($sformatf("dial_complete expected %0b actual %0b", want.complete, dc));
		endfunction
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        item_valid    = 1'b0;
	logic        item_stall;
	mode_t       mode          = MODE_CLEAR;
	logic [3:0]  entry         = '0;
	logic [4:0]  position      = '0;
	logic [12:0] mask          = '0;
	logic [5:0]  length        = '0;
	logic        variable      = 1'b0;
	logic [3:0]  key           = '0;
	logic        result_valid;
	logic        result_stall  = 1'b0;
	logic [1:0]  status;
	logic        dial_complete;

	digit_map_tracker board = new();
	int sent;
	int idle_pct;
	int stall_pct;
	bit hold_req;

	dial_digit_map_matcher i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.entry        (entry),
		.position     (position),
		.mask         (mask),
		.length       (length),
		.variable     (variable),
		.key          (key),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.dial_complete(dial_complete)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("dial_digit_map_matcher_tb: errors");
		$finish;
	end

	// Result side: check, then pick the stall for the next cycle.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall)
				board.check_result(status, dial_complete);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic send_item(input mode_t m, input bit [3:0] e, input bit [4:0] p,
			input bit [12:0] msk, input bit [5:0] len, input bit dot, input bit [3:0] k);
		item_valid <= 1'b1;
		mode <= m;
		entry <= e;
		position <= p;
		mask <= msk;
		length <= len;
		variable <= dot;
		key <= k;
		do @(posedge clk); while (item_stall);
		board.note_transaction(m, e, p, msk, len, dot, k);
		sent++;
		if ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic put_mask(input int e, input int p, input bit [12:0] msk);
		send_item(MODE_MASK_WR, 4'(e), 5'(p), msk, 6'($urandom), 1'($urandom), 4'($urandom));
	endtask

	task automatic put_header(input int e, input int len, input bit dot);
		send_item(MODE_HDR_WR, 4'(e), 5'($urandom), 13'($urandom), 6'(len), dot, 4'($urandom));
	endtask

	task automatic clear_dial();
		send_item(MODE_CLEAR, 4'($urandom), 5'($urandom), 13'($urandom), 6'($urandom),
			1'($urandom), 4'($urandom));
	endtask

	task automatic press(input bit [3:0] k);
		send_item(MODE_KEY, 4'($urandom), 5'($urandom), 13'($urandom), 6'($urandom),
			1'($urandom), k);
	endtask

	// Mostly mask shapes a real dial plan uses: any digit, one key, '#'.
	function automatic bit [12:0] map_mask();
		case ($urandom_range(7))
			0, 1:    return 13'h03ff;
			2:       return 13'h0001;
			3:       return 13'h1000;
			4, 5:    return 13'(1 << $urandom_range(12));
			6:       return 13'($urandom);
			default: return 13'h1fff;
		endcase
	endfunction

	function automatic bit [3:0] pick_key(bit [12:0] m);
		int b;
		if (m == 0 || $urandom_range(9) == 0)
			return 4'($urandom_range(15));
		do b = $urandom_range(12); while (!m[b]);
		return 4'(b);
	endfunction

	task automatic rewrite_entry(input int e);
		int l;
		bit dot;
		case ($urandom_range(9))
			0:       l = 0;
			1:       l = $urandom_range(7, 32);
			2:       l = $urandom_range(33, 63);
			default: l = $urandom_range(1, 6);
		endcase
		dot = 1'($urandom_range(1));
		put_header(e, l, dot);
		for (int i = 0; i < l && i < N_POS; i++)
			if ($urandom_range(4) != 0)
				put_mask(e, i, map_mask());
	endtask

	// Dial a number that follows one entry, with the odd wrong or extra key.
	task automatic dial_episode();
		int e;
		int l;
		if ($urandom_range(9) != 0)
			clear_dial();
		e = $urandom_range(N_ENTRIES - 1);
		l = int'(board.lens[e]);
		if (l == 0 || (board.dot_form[e] && l < 2)) begin
			repeat ($urandom_range(1, 4)) press(4'($urandom_range(15)));
		end else if (!board.dot_form[e]) begin
			for (int i = 0; i < l; i++)
				press(pick_key(board.mask_of(e, i)));
		end else begin
			for (int i = 0; i < l - 1; i++)
				press(pick_key(board.mask_of(e, i)));
			repeat ($urandom_range(0, 4)) press(pick_key(board.mask_of(e, l - 2)));
			press(pick_key(board.mask_of(e, l - 1)));
		end
		if ($urandom_range(4) == 0)
			repeat ($urandom_range(1, 3)) press(4'($urandom_range(15)));
	endtask

	initial begin
		int idle_plan[4];
		int stall_plan[4];
		int goal;
		int waited;
		idle_plan = '{0, 68, 0, 31};
		stall_plan = '{0, 0, 68, 31};
		idle_pct = 0;
		stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load every mask word so no key press ever reads an unwritten one
		for (int e = 0; e < N_ENTRIES; e++)
			for (int p = 0; p < N_POS; p++)
				put_mask(e, p, map_mask());

		put_header(0, 3, 1'b0);
		put_mask(0, 0, 13'h0001);
		put_mask(0, 1, 13'h03ff);
		put_mask(0, 2, 13'h03ff);
		put_header(1, 3, 1'b1);
		put_mask(1, 0, 13'h03ff);
		put_mask(1, 1, 13'h03ff);
		put_mask(1, 2, 13'h1000);
		put_header(2, 0, 1'b1);
		put_header(3, 1, 1'b1);
		put_header(4, 63, 1'b0);
		put_header(5, 32, 1'b1);
		put_mask(5, 31, 13'h1fff);
		clear_dial();
		press(4'd0);
		press(4'd5);
		press(4'd9);
		press(4'd15);
		clear_dial();
		press(4'd3);
		press(4'd7);
		press(4'd7);
		press(4'd12);
		press(4'd13);
		clear_dial();
		press(4'd3);
		// change the table in the middle of a number
		put_mask(1, 1, 13'h0000);
		press(4'd7);

		for (int e = 0; e < N_ENTRIES; e++)
			rewrite_entry(e);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_plan[ph];
			stall_pct = stall_plan[ph];
			if (ph == 0)
				hold_req = 1'b1;
			if (ph == 2) begin
				// run the key count into saturation on an open-ended entry
				put_header(6, 3, 1'b1);
				put_mask(6, 0, 13'h03ff);
				put_mask(6, 1, 13'h03ff);
				put_mask(6, 2, 13'h1000);
				clear_dial();
				repeat (262) press(4'($urandom_range(9)));
				press(4'd12);
			end
			goal = sent + 140;
			while (sent < goal) begin
				case ($urandom_range(19))
					0, 1, 2: rewrite_entry($urandom_range(N_ENTRIES - 1));
					3, 4: begin
						repeat ($urandom_range(1, 4))
							send_item(mode_t'($urandom_range(3)), 4'($urandom), 5'($urandom),
								13'($urandom), 6'($urandom), 1'($urandom), 4'($urandom));
					end
					default: dial_episode();
				endcase
			end
		end
		item_valid <= 1'b0;

		waited = 0;
		while (board.verdicts_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (board.verdicts_due.size() != 0) begin
			$display("%0t: %0d key results never arrived", $time, board.verdicts_due.size());
			board.errors++;
		end
		repeat (50) @(posedge clk);

		$display("%0d transactions sent, %0d key results checked (%0d full, %0d partial)",
			sent, board.checked, board.fulls, board.partials);
		$display("key count saturation %s, %0d failures",
			board.saturated ? "reached" : "not reached", board.errors);
		if (board.errors == 0)
			$display("dial_digit_map_matcher_tb: clean");
		else
			$display("dial_digit_map_matcher_tb: errors");
		$finish;
	end

endmodule

// File: files.f
rtl/ddmm_pkg.sv
rtl/ddmm_ctrl.sv
rtl/ddmm_dpath.sv
rtl/dial_digit_map_matcher.sv
test/dial_digit_map_matcher_tb.sv
